// File: src/rkpr_pkg.sv
// Package for the reactive key pulse renderer core.
// Holds the command codes, register indexes, sequencer states and fixed widths.
// No dependencies.
`timescale 1ns / 1ps

package rkpr_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_KEY   = 2'd1,
    CMD_PULSE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  localparam logic [1:0] REG_KEY_COLOR  = 2'd0;
  localparam logic [1:0] REG_PULSE_COLOR = 2'd1;
  localparam logic [1:0] REG_PULSE_DIST = 2'd2;

  // signed pixel coordinate, covers clamped pulse boxes and key edges
  localparam int CRD_W = 13;
  // squared distance in Q24
  localparam int D2_W = 49;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RDPX,
    ST_RDQ,
    ST_KEY,
    ST_CTR,
    ST_BOX,
    ST_ROOT,
    ST_PX_RD,
    ST_SQX,
    ST_SQY,
    ST_SUM,
    ST_DIVC,
    ST_DIV,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_BLEND,
    ST_ADV,
    ST_DONE
  } state_t;

endpackage

// File: src/reactive_key_pulse_renderer_core.sv
// Reactive key pulse renderer: RGB888 frame store with pixel, key and pulse drawing.
// Depends on rkpr_pkg.
//
// Usage: one command per transfer on the in_ channel (write pixel, draw pressed key,
// draw pulse, read pixel); every command returns exactly one result transfer on the
// out_ channel carrying out_read_color (read only, else zero) and out_skipped (pulse
// key of zero area). The cfg_ channel writes key_down_color, pulse_color and
// pulse_distance; it is always ready, and the user must write it only while the block
// is idle; the block itself does not enforce this. Per command, on the frame memory
// and the shared multiplier: write pixel writes; read pixel reads, captures; pressed
// key, one write a cycle; pulse: centre, box, fade fourth root (skipped at full
// fade); per pixel: read, two squares, 16-step divide, three multiplies, blend, write.
// One command is in work at a time; in_ready is high whenever the sequencer is idle,
// also while a finished result waits in the output register.
// If the receiver stalls, the result holds in the output register and the next
// finished command waits until it is taken.
// Reset sets the cfg registers to their defaults, clears out_valid and idles the
// sequencer; the frame store is not cleared and reads as undefined until written.
`timescale 1ns / 1ps

module reactive_key_pulse_renderer_core
  import rkpr_pkg::*;
#(
  parameter int FRAME_WIDTH  = 128,
  parameter int FRAME_HEIGHT = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_left,
  input  logic [5:0]  in_top,
  input  logic [7:0]  in_right,
  input  logic [5:0]  in_bottom,
  input  logic [8:0]  in_fade,
  input  logic [23:0] in_pixel_color,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_read_color,
  output logic        out_skipped,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XBW   = $clog2(FRAME_WIDTH);
  localparam int YBW   = $clog2(FRAME_HEIGHT);
  localparam logic signed [CRD_W-1:0] FW_C = CRD_W'(FRAME_WIDTH);
  localparam logic signed [CRD_W-1:0] FH_C = CRD_W'(FRAME_HEIGHT);

  state_t state_r, state_nxt;

  logic [23:0]        kdc_r, pcol_r;
  logic signed [12:0] pdist_r;

  logic [7:0] key_l_r, key_r_r;
  logic [5:0] key_t_r, key_b_r;
  logic [8:0] fsat_r;
  logic [5:0] h_r;

  logic signed [23:0] cx_r, cy_r, hq_r;
  logic [19:0]        dsor_r;
  logic signed [CRD_W-1:0] x0_r, x1_r, y0_r, y1_r, x_r, y_r;

  logic [63:0] sq_n_r, sq_q_r, sq_bit_r;
  logic        pass_r;
  logic [16:0] root_r;

  logic [23:0]     dxm_r, dym_r;
  logic [47:0]     prod_r;
  logic [D2_W-1:0] d2_r;
  logic [34:0]     dv_r;
  logic [3:0]      div_cnt_r;
  logic [16:0]     rr_r;

  logic [23:0] rd_r;
  logic        sk_r;
  logic        out_valid_r;
  logic [23:0] out_color_r;
  logic        out_skip_r;

  logic [23:0] mem [DEPTH];
  logic [23:0] mem_q_r;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [23:0]   mem_wdata;

  // ---- combinational helpers
  logic          in_acc, in_frame_port, key_empty, pulse_zero;
  logic signed [CRD_W-1:0] kl, kt, kr, kb, kx0, kx1, ky0, ky1;
  logic signed [CRD_W-1:0] fx0, fx1, fy0, fy1, bx0, bx1, by0, by1;
  logic signed [23:0] lo_x, hi_x, lo_y, hi_y;
  logic          box_empty, last_px, px_in_frame, rd_in_frame, key_edge, pulse_edge;
  logic [AW-1:0] px_addr, port_addr, rd_addr;
  logic signed [24:0] dx, dy;
  logic [64:0]   sq_sum;
  logic [63:0]   sq_new;
  logic          sq_ge;
  logic [23:0]   mul_a, mul_b;
  logic [47:0]   mul_p;
  logic [16:0]   alpha;
  logic [23:0]   tgt, blend_px;
  logic signed [8:0]  diff;
  logic signed [26:0] term;
  logic signed [27:0] acc;
  logic [7:0]    ch_old, ch_tgt;
  logic signed [22:0] mv;
  logic [7:0]    edge_x;

  assign in_acc        = in_valid && in_ready;
  assign in_frame_port = (32'(in_left) < FRAME_WIDTH) && (32'(in_top) < FRAME_HEIGHT);
  assign port_addr     = AW'(in_top) * AW'(FRAME_WIDTH) + AW'(in_left);
  assign rd_in_frame   = (32'(key_l_r) < FRAME_WIDTH) && (32'(key_t_r) < FRAME_HEIGHT);
  assign rd_addr       = AW'(key_t_r) * AW'(FRAME_WIDTH) + AW'(key_l_r);
  assign px_addr       = AW'(y_r[YBW-1:0]) * AW'(FRAME_WIDTH) + AW'(x_r[XBW-1:0]);
  assign px_in_frame   = (x_r < FW_C) && (y_r < FH_C);
  assign last_px       = (x_r == x1_r) && (y_r == y1_r);
  assign pulse_zero    = (in_right <= in_left) || (in_bottom <= in_top);

  always_comb begin
    kl  = CRD_W'(in_left);
    kt  = CRD_W'(in_top);
    kr  = CRD_W'(in_right);
    kb  = CRD_W'(in_bottom);
    kx0 = (kl == 0) ? '0 : kl - 13'sd1;
    ky0 = (kt == 0) ? '0 : kt - 13'sd1;
    kx1 = (kr > FW_C - 13'sd1) ? FW_C - 13'sd1 : kr;
    ky1 = (kb > FH_C - 13'sd1) ? FH_C - 13'sd1 : kb;
    key_empty = (kx0 > kx1) || (ky0 > ky1);
  end

  always_comb begin
    lo_x = cx_r - hq_r;
    hi_x = cx_r + hq_r + 24'sd4095;
    lo_y = cy_r - hq_r;
    hi_y = cy_r + hq_r + 24'sd4095;
    fx0  = $signed({lo_x[23], lo_x[23:12]}) - 13'sd1;
    fy0  = $signed({lo_y[23], lo_y[23:12]}) - 13'sd1;
    fx1  = $signed({hi_x[23], hi_x[23:12]}) + 13'sd1;
    fy1  = $signed({hi_y[23], hi_y[23:12]}) + 13'sd1;
    bx0  = (fx0 < 0) ? '0 : fx0;
    by0  = (fy0 < 0) ? '0 : fy0;
    bx1  = (fx1 > FW_C) ? FW_C : fx1;
    by1  = (fy1 > FH_C) ? FH_C : fy1;
    box_empty = (bx0 > bx1) || (by0 > by1);
  end

  always_comb begin
    edge_x = (pdist_r > 0) ? key_l_r : key_r_r;
    mv     = pdist_r * $signed({1'b0, 9'd256 - fsat_r});
  end

  assign key_edge = (x_r < $signed(CRD_W'(key_l_r))) || (y_r < $signed(CRD_W'(key_t_r))) ||
                    (x_r >= $signed(CRD_W'(key_r_r))) || (y_r >= $signed(CRD_W'(key_b_r)));
  assign pulse_edge = (x_r == x0_r) || (y_r == y0_r) || (x_r == x1_r) || (y_r == y1_r);

  assign dx = $signed({x_r, 12'b0}) - $signed({cx_r[23], cx_r});
  assign dy = $signed({y_r, 12'b0}) - $signed({cy_r[23], cy_r});

  assign sq_sum = {1'b0, sq_q_r} + {1'b0, sq_bit_r};
  assign sq_ge  = {1'b0, sq_n_r} >= sq_sum;
  assign sq_new = sq_ge ? (sq_q_r >> 1) + sq_bit_r : (sq_q_r >> 1);

  always_comb begin
    case (state_r)
      ST_SQX:  begin mul_a = dxm_r; mul_b = dxm_r; end
      ST_SQY:  begin mul_a = dym_r; mul_b = dym_r; end
      ST_M1:   begin mul_a = 24'(rr_r); mul_b = 24'(rr_r); end
      ST_M2:   begin mul_a = 24'(prod_r[32:16]); mul_b = 24'(prod_r[32:16]); end
      ST_M3:   begin mul_a = 24'(17'd65536 - prod_r[32:16]); mul_b = 24'(root_r); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign alpha = prod_r[32:16];
  assign tgt   = pulse_edge ? 24'd0 : pcol_r;

  always_comb begin
    blend_px = '0;
    diff     = '0;
    term     = '0;
    acc      = '0;
    ch_old   = '0;
    ch_tgt   = '0;
    for (int k = 0; k < 3; k++) begin
      ch_old = mem_q_r[8*k +: 8];
      ch_tgt = tgt[8*k +: 8];
      diff   = $signed({1'b0, ch_tgt}) - $signed({1'b0, ch_old});
      term   = diff * $signed({1'b0, alpha});
      acc    = $signed({4'b0, ch_old, 16'b0}) + {term[26], term} + 28'sd32768;
      blend_px[8*k +: 8] = acc[23:16];
    end
  end

  // ---- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (cmd_t'(in_cmd))
            CMD_WRITE: state_nxt = ST_DONE;
            CMD_KEY:   state_nxt = key_empty ? ST_DONE : ST_KEY;
            CMD_PULSE: state_nxt = pulse_zero ? ST_DONE : ST_CTR;
            default:   state_nxt = ST_RDPX;
          endcase
        end
      end
      ST_RDPX:  state_nxt = ST_RDQ;
      ST_RDQ:   state_nxt = ST_DONE;
      ST_KEY:   state_nxt = last_px ? ST_DONE : ST_KEY;
      ST_CTR:   state_nxt = ST_BOX;
      ST_BOX: begin
        if (box_empty) state_nxt = ST_DONE;
        else if (fsat_r[8]) state_nxt = ST_PX_RD;
        else state_nxt = ST_ROOT;
      end
      ST_ROOT:  state_nxt = (sq_bit_r[0] && pass_r) ? ST_PX_RD : ST_ROOT;
      ST_PX_RD: state_nxt = px_in_frame ? ST_SQX : ST_ADV;
      ST_SQX:   state_nxt = ST_SQY;
      ST_SQY:   state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_DIVC;
      ST_DIVC:  state_nxt = (d2_r >= D2_W'({dsor_r, 16'b0})) ? ST_M1 : ST_DIV;
      ST_DIV:   state_nxt = (div_cnt_r == 4'd15) ? ST_M1 : ST_DIV;
      ST_M1:    state_nxt = ST_M2;
      ST_M2:    state_nxt = ST_M3;
      ST_M3:    state_nxt = ST_BLEND;
      ST_BLEND: state_nxt = ST_ADV;
      ST_ADV:   state_nxt = last_px ? ST_DONE : ST_PX_RD;
      ST_DONE:  state_nxt = (!out_valid_r || out_ready) ? ST_IDLE : ST_DONE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // ---- handshake and memory controls
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    cfg_ready = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = px_addr;
    mem_wdata = blend_px;
    mem_re    = 1'b0;
    mem_raddr = px_addr;
    case (state_r)
      ST_IDLE: begin
        mem_we    = in_acc && (cmd_t'(in_cmd) == CMD_WRITE) && in_frame_port;
        mem_waddr = port_addr;
        mem_wdata = in_pixel_color;
      end
      ST_KEY: begin
        mem_we    = 1'b1;
        mem_wdata = key_edge ? 24'd0 : kdc_r;
      end
      ST_BLEND: mem_we = 1'b1;
      ST_RDPX: begin
        mem_re    = rd_in_frame;
        mem_raddr = rd_addr;
      end
      ST_PX_RD: mem_re = px_in_frame;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_q_r <= mem[mem_raddr];
  end

  // ---- control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      kdc_r       <= 24'hFFFFFF;
      pcol_r      <= 24'hFFFFFF;
      pdist_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KEY_COLOR:   kdc_r   <= cfg_data;
          REG_PULSE_COLOR: pcol_r  <= cfg_data;
          REG_PULSE_DIST:  pdist_r <= $signed(cfg_data[12:0]);
          default: ;
        endcase
      end
      if (state_r == ST_DONE && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // ---- datapath
  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && (!out_valid_r || out_ready)) begin
      out_color_r <= rd_r;
      out_skip_r  <= sk_r;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          key_l_r <= in_left;
          key_t_r <= in_top;
          key_r_r <= in_right;
          key_b_r <= in_bottom;
          fsat_r  <= (in_fade > 9'd256) ? 9'd256 : in_fade;
          h_r     <= in_bottom - in_top;
          rd_r    <= '0;
          sk_r    <= (cmd_t'(in_cmd) == CMD_PULSE) && pulse_zero;
          x0_r    <= kx0;
          x1_r    <= kx1;
          y0_r    <= ky0;
          y1_r    <= ky1;
          x_r     <= kx0;
          y_r     <= ky0;
        end
      end
      ST_RDQ: rd_r <= rd_in_frame ? mem_q_r : 24'd0;
      ST_CTR: begin
        cx_r   <= $signed({4'b0, edge_x, 12'b0}) + $signed({mv[22], mv});
        cy_r   <= $signed({6'b0, 7'(key_t_r) + 7'(key_b_r), 11'b0});
        hq_r   <= $signed({6'b0, h_r, 12'b0});
        dsor_r <= {12'(h_r * h_r), 8'b0};
      end
      ST_BOX: begin
        x0_r     <= bx0;
        x1_r     <= bx1;
        y0_r     <= by0;
        y1_r     <= by1;
        x_r      <= bx0;
        y_r      <= by0;
        root_r   <= 17'd65536;
        sq_n_r   <= {fsat_r[7:0], 56'b0};
        sq_q_r   <= '0;
        sq_bit_r <= 64'd1 << 62;
        pass_r   <= 1'b0;
      end
      ST_ROOT: begin
        if (sq_bit_r[0]) begin
          if (pass_r) begin
            root_r <= sq_new[16:0];
          end else begin
            sq_n_r   <= sq_new;
            sq_q_r   <= '0;
            sq_bit_r <= 64'd1 << 62;
            pass_r   <= 1'b1;
          end
        end else begin
          if (sq_ge) sq_n_r <= sq_n_r - sq_sum[63:0];
          sq_q_r   <= sq_new;
          sq_bit_r <= sq_bit_r >> 2;
        end
      end
      ST_PX_RD: begin
        dxm_r <= dx[24] ? 24'(-dx) : dx[23:0];
        dym_r <= dy[24] ? 24'(-dy) : dy[23:0];
      end
      ST_SQX: prod_r <= mul_p;
      ST_SQY: begin
        d2_r   <= D2_W'(prod_r);
        prod_r <= mul_p;
      end
      ST_SUM: d2_r <= d2_r + D2_W'(prod_r);
      ST_DIVC: begin
        rr_r      <= (d2_r >= D2_W'({dsor_r, 16'b0})) ? 17'd65536 : 17'd0;
        dv_r      <= {dsor_r, 15'b0};
        div_cnt_r <= '0;
      end
      ST_DIV: begin
        if (d2_r >= D2_W'(dv_r)) begin
          d2_r <= d2_r - D2_W'(dv_r);
          rr_r <= {rr_r[15:0], 1'b1};
        end else begin
          rr_r <= {rr_r[15:0], 1'b0};
        end
        dv_r      <= dv_r >> 1;
        div_cnt_r <= div_cnt_r + 4'd1;
      end
      ST_M1, ST_M2, ST_M3: prod_r <= mul_p;
      default: ;
    endcase
    if (state_r == ST_KEY || state_r == ST_ADV) begin
      if (x_r == x1_r) begin
        x_r <= x0_r;
        y_r <= y_r + 13'sd1;
      end else begin
        x_r <= x_r + 13'sd1;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_color = out_color_r;
  assign out_skipped    = out_skip_r;

endmodule
